/* sv/quadratic_bezier_point_generator_top_macros.svh */
// Assertion helpers for the Bezier sampler checker.
`ifndef QUADRATIC_BEZIER_POINT_GENERATOR_TOP_MACROS_SVH
`define QUADRATIC_BEZIER_POINT_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QBPG_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define QBPG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/qbpg_pkg.sv */
package qbpg_pkg;

	localparam int MAX_POINTS  = 32;
	localparam int RESULT_CAP  = 32;
	localparam int POINT_LIMIT = (MAX_POINTS < RESULT_CAP) ? MAX_POINTS : RESULT_CAP;

	localparam int COORD_W = 16;
	localparam int IDX_W   = 5;
	localparam int CNT_W   = 6;
	localparam int T_W     = 17;   // Q0.16 plus one integer bit for t = 1.0
	localparam int WGT_W   = 33;   // Q0.32 weights, 2^32 included
	localparam int PROD_W  = 49;   // signed weight * coordinate

	localparam int CNT_RESET = 16;
	localparam int RECIP_NUM = 65536;
	localparam logic [T_W-1:0] T_ONE = T_W'(RECIP_NUM);

	// Per-sample increment of t = i * 2^16 / d, split into quotient and remainder.
	// Indexed by d = count - 1; d = 0 means a single sample and never steps.
	localparam logic [T_W-1:0] STEP_Q [32] = '{
		17'd0,             17'(RECIP_NUM / 1),  17'(RECIP_NUM / 2),  17'(RECIP_NUM / 3),
		17'(RECIP_NUM / 4),  17'(RECIP_NUM / 5),  17'(RECIP_NUM / 6),  17'(RECIP_NUM / 7),
		17'(RECIP_NUM / 8),  17'(RECIP_NUM / 9),  17'(RECIP_NUM / 10), 17'(RECIP_NUM / 11),
		17'(RECIP_NUM / 12), 17'(RECIP_NUM / 13), 17'(RECIP_NUM / 14), 17'(RECIP_NUM / 15),
		17'(RECIP_NUM / 16), 17'(RECIP_NUM / 17), 17'(RECIP_NUM / 18), 17'(RECIP_NUM / 19),
		17'(RECIP_NUM / 20), 17'(RECIP_NUM / 21), 17'(RECIP_NUM / 22), 17'(RECIP_NUM / 23),
		17'(RECIP_NUM / 24), 17'(RECIP_NUM / 25), 17'(RECIP_NUM / 26), 17'(RECIP_NUM / 27),
		17'(RECIP_NUM / 28), 17'(RECIP_NUM / 29), 17'(RECIP_NUM / 30), 17'(RECIP_NUM / 31)
	};

	localparam logic [IDX_W-1:0] STEP_R [32] = '{
		5'd0,             5'(RECIP_NUM % 1),  5'(RECIP_NUM % 2),  5'(RECIP_NUM % 3),
		5'(RECIP_NUM % 4),  5'(RECIP_NUM % 5),  5'(RECIP_NUM % 6),  5'(RECIP_NUM % 7),
		5'(RECIP_NUM % 8),  5'(RECIP_NUM % 9),  5'(RECIP_NUM % 10), 5'(RECIP_NUM % 11),
		5'(RECIP_NUM % 12), 5'(RECIP_NUM % 13), 5'(RECIP_NUM % 14), 5'(RECIP_NUM % 15),
		5'(RECIP_NUM % 16), 5'(RECIP_NUM % 17), 5'(RECIP_NUM % 18), 5'(RECIP_NUM % 19),
		5'(RECIP_NUM % 20), 5'(RECIP_NUM % 21), 5'(RECIP_NUM % 22), 5'(RECIP_NUM % 23),
		5'(RECIP_NUM % 24), 5'(RECIP_NUM % 25), 5'(RECIP_NUM % 26), 5'(RECIP_NUM % 27),
		5'(RECIP_NUM % 28), 5'(RECIP_NUM % 29), 5'(RECIP_NUM % 30), 5'(RECIP_NUM % 31)
	};

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic [WGT_W-1:0] wa;   // (1-t)^2
		logic [WGT_W-1:0] wb;   // 2(1-t)t
		logic [WGT_W-1:0] wc;   // t^2
	} weights_t;

	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic             last;
		weights_t         w;
	} sample_t;

endpackage

/* sv/qbpg_seq.sv */
module qbpg_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          start,
	input  logic [qbpg_pkg::CNT_W-1:0]    point_count,
	output logic                          idle,
	output logic                          valid_s1,
	output qbpg_pkg::sample_t             sample_s1
);

	qbpg_pkg::state_t state_q, state_d;

	logic [qbpg_pkg::CNT_W-1:0] cnt_sat;
	logic [qbpg_pkg::IDX_W-1:0] d_in;

	logic [qbpg_pkg::IDX_W-1:0] idx_q, last_q, rem_q, stepr_q;
	logic [qbpg_pkg::T_W-1:0]   t_q, stepq_q;

	logic                         cur_last, issue, wrap;
	logic [qbpg_pkg::IDX_W:0]     rem_sum;
	logic [qbpg_pkg::T_W-1:0]     t_cur, u_cur;
	logic [2*qbpg_pkg::T_W-1:0]   uu, ut, tt;

	// zero count acts as one; clamp to the result cap
	always_comb begin
		cnt_sat = (point_count == '0) ? qbpg_pkg::CNT_W'(1) : point_count;
		if (cnt_sat > qbpg_pkg::CNT_W'(qbpg_pkg::POINT_LIMIT))
			cnt_sat = qbpg_pkg::CNT_W'(qbpg_pkg::POINT_LIMIT);
		d_in = qbpg_pkg::IDX_W'(cnt_sat - qbpg_pkg::CNT_W'(1));
	end

	assign idle     = (state_q == qbpg_pkg::ST_IDLE);
	assign cur_last = (idx_q == last_q);
	assign issue    = (state_q == qbpg_pkg::ST_RUN) && adv;

	// final sample runs with t = 1.0, which yields the end point exactly
	assign t_cur = cur_last ? qbpg_pkg::T_ONE : t_q;
	assign u_cur = qbpg_pkg::T_ONE - t_cur;
	assign uu    = u_cur * u_cur;
	assign ut    = u_cur * t_cur;
	assign tt    = t_cur * t_cur;

	assign rem_sum = {1'b0, rem_q} + {1'b0, stepr_q};
	assign wrap    = (rem_sum >= {1'b0, last_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= qbpg_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			qbpg_pkg::ST_IDLE: begin
				if (start)
					state_d = qbpg_pkg::ST_RUN;
			end
			qbpg_pkg::ST_RUN: begin
				if (adv && cur_last)
					state_d = qbpg_pkg::ST_IDLE;
			end
			default: state_d = qbpg_pkg::ST_IDLE;
		endcase
	end

	// t advances by a table quotient; remainder carries into t when it reaches d
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			last_q  <= '0;
			rem_q   <= '0;
			stepr_q <= '0;
			t_q     <= '0;
			stepq_q <= '0;
		end else if (start) begin
			idx_q   <= '0;
			last_q  <= d_in;
			rem_q   <= '0;
			t_q     <= '0;
			stepq_q <= qbpg_pkg::STEP_Q[d_in];
			stepr_q <= qbpg_pkg::STEP_R[d_in];
		end else if (issue && !cur_last) begin
			idx_q <= idx_q + qbpg_pkg::IDX_W'(1);
			if (wrap) begin
				rem_q <= qbpg_pkg::IDX_W'(rem_sum - {1'b0, last_q});
				t_q   <= t_q + stepq_q + qbpg_pkg::T_W'(1);
			end else begin
				rem_q <= qbpg_pkg::IDX_W'(rem_sum);
				t_q   <= t_q + stepq_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (adv)
			valid_s1 <= issue;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sample_s1.index <= idx_q;
			sample_s1.last  <= cur_last;
			sample_s1.w.wa  <= qbpg_pkg::WGT_W'(uu);
			sample_s1.w.wb  <= {ut[qbpg_pkg::WGT_W-2:0], 1'b0};
			sample_s1.w.wc  <= qbpg_pkg::WGT_W'(tt);
		end
	end

endmodule

/* sv/qbpg_lane.sv */
module qbpg_lane (
	input  logic                                clk,
	input  logic                                adv,
	input  logic                                load,
	input  logic signed [qbpg_pkg::COORD_W-1:0] p0,
	input  logic signed [qbpg_pkg::COORD_W-1:0] p1,
	input  logic signed [qbpg_pkg::COORD_W-1:0] p2,
	input  qbpg_pkg::weights_t                  w_s1,
	output logic signed [qbpg_pkg::COORD_W-1:0] coord_s2
);

	logic signed [qbpg_pkg::COORD_W-1:0] p0_q, p1_q, p2_q;
	logic signed [qbpg_pkg::PROD_W-1:0]  prod_a_s2, prod_b_s2, prod_c_s2, acc;

	always_ff @(posedge clk) begin
		if (load) begin
			p0_q <= p0;
			p1_q <= p1;
			p2_q <= p2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_a_s2 <= qbpg_pkg::PROD_W'($signed({1'b0, w_s1.wa}) * p0_q);
			prod_b_s2 <= qbpg_pkg::PROD_W'($signed({1'b0, w_s1.wb}) * p1_q);
			prod_c_s2 <= qbpg_pkg::PROD_W'($signed({1'b0, w_s1.wc}) * p2_q);
		end
	end

	// weights sum to 2^32, so the blend stays in range; floor = arithmetic shift
	assign acc      = prod_a_s2 + prod_b_s2 + prod_c_s2;
	assign coord_s2 = acc[32 +: qbpg_pkg::COORD_W];

endmodule

/* sv/quadratic_bezier_point_generator_top.sv */
// Quadratic Bezier sampler, 3D. One input transfer carries start point P0,
// control point P1 and end point P2 (signed Q7.8 per axis). The block then
// emits point_count samples, index 0..n-1, with t = floor(i*2^16/(n-1)) in
// Q0.16 and each coordinate floor((1-t)^2*P0 + 2(1-t)t*P1 + t^2*P2); the
// final sample (tlast) is exactly P2. A count of 0 acts as 1; counts above
// 32 clamp to 32. After the request transfer the sequencer issues one sample
// per cycle while the output is not stalled; its single t step per cycle
// sets the rate. Each sample passes the stage-1, product and output registers.
// The next request is taken once the sequencer has issued the last sample
// and stage 1 can move on, while samples in flight drain. The user must write
// point_count over the cfg channel only while no request is open (unenforced).
module quadratic_bezier_point_generator_top (
	input  logic         clk,
	input  logic         arst_n,
	// configuration: point_count
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [5:0]   cfg_data,
	// request channel
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// start_x, start_y, start_z, ctrl_x, ctrl_y, ctrl_z, end_x, end_y, end_z
	input  logic [143:0] s_axis_tdata,
	// sample channel
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// sample_index[4:0], out_x[20:5], out_y[36:21], out_z[52:37], zero pad
	output logic [55:0]  m_axis_tdata,
	output logic         m_axis_tlast   // is_last
);

	localparam int CW = qbpg_pkg::COORD_W;

	logic [qbpg_pkg::CNT_W-1:0] point_count_q;

	logic              adv;          // whole pipeline moves when the output slot frees
	logic              start;        // request transfer
	logic              seq_idle;
	logic              valid_s1;
	qbpg_pkg::sample_t sample_s1;

	logic                       valid_s2, last_s2;
	logic [qbpg_pkg::IDX_W-1:0] index_s2;

	logic signed [CW-1:0] coord_s2 [3];

	logic                       out_valid_q, out_last_q;
	logic [qbpg_pkg::IDX_W-1:0] out_index_q;
	logic signed [CW-1:0]       out_coord_q [3];

	// config register; always ready; user must let writes land only between requests, unenforced
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			point_count_q <= qbpg_pkg::CNT_W'(qbpg_pkg::CNT_RESET);
		else if (cfg_valid && cfg_ready)
			point_count_q <= cfg_data;
	end

	assign adv = !out_valid_q || m_axis_tready;

	// Each lane holds its points for the product stage. A new request
	// may only land once the stage-1 sample, if any, moves on this same edge.
	assign s_axis_tready = seq_idle && (!valid_s1 || adv);
	assign start         = s_axis_tvalid && s_axis_tready;

	// sequencer: t stepping and weight generation (stage 1)
	qbpg_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.start      (start),
		.point_count(point_count_q),
		.idle       (seq_idle),
		.valid_s1   (valid_s1),
		.sample_s1  (sample_s1)
	);

	// one lane per axis: held points, weighted products (stage 2), blend sum
	for (genvar k = 0; k < 3; k++) begin : g_lane
		qbpg_lane u_lane (
			.clk     (clk),
			.adv     (adv),
			.load    (start),
			.p0      ($signed(s_axis_tdata[CW*k +: CW])),
			.p1      ($signed(s_axis_tdata[CW*(k+3) +: CW])),
			.p2      ($signed(s_axis_tdata[CW*(k+6) +: CW])),
			.w_s1    (sample_s1.w),
			.coord_s2(coord_s2[k])
		);
	end

	// sideband alongside the lane products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			index_s2 <= sample_s1.index;
			last_s2  <= sample_s1.last;
		end
	end

	// merge: three lane results plus index into one output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_index_q    <= index_s2;
			out_last_q     <= last_s2;
			out_coord_q[0] <= coord_s2[0];
			out_coord_q[1] <= coord_s2[1];
			out_coord_q[2] <= coord_s2[2];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {3'b000, out_coord_q[2], out_coord_q[1], out_coord_q[0],
		out_index_q};

endmodule

/* sv/qbpg_checker.sv */
`include "quadratic_bezier_point_generator_top_macros.svh"

module qbpg_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [55:0]  m_axis_tdata,
	input logic         m_axis_tlast
);

	logic [4:0] next_idx_q;
	logic       s_xfer, m_xfer;

	assign s_xfer = s_axis_tvalid && s_axis_tready;
	assign m_xfer = m_axis_tvalid && m_axis_tready;

	// expected sample index: restarts after each tlast transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			next_idx_q <= '0;
		else if (m_xfer)
			next_idx_q <= m_axis_tlast ? 5'd0 : m_axis_tdata[4:0] + 5'd1;
	end

	`QBPG_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
		"stalled sample changed")

	`QBPG_ASSERT_NOW(a_index_seq, clk, arst_n, m_axis_tvalid,
		m_axis_tdata[4:0] == next_idx_q, "sample index out of sequence")

	`QBPG_ASSERT_NEXT(a_req_busy, clk, arst_n, s_xfer, !s_axis_tready,
		"request taken while sequencer busy")

	`QBPG_ASSERT_NOW(a_pad_zero, clk, arst_n, m_axis_tvalid,
		m_axis_tdata[55:53] == 3'b000, "sample padding not zero")

endmodule

bind quadratic_bezier_point_generator_top qbpg_checker u_qbpg_checker (.*);

/* tb/quadratic_bezier_point_generator_top_test.sv */
module quadratic_bezier_point_generator_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	// One expected sample on the output stream.
	typedef struct packed {
		logic [4:0]  index;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
		logic        last;
	} curve_point_t;

	localparam int STALL_LIMIT = 3000;   // quiet cycles before the run is declared hung
	localparam int LONG_HOLD   = 400;    // receiver hold-off used to back up the block

	logic         clk;
	logic         arst_n;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [5:0]   cfg_data;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	// start_x, start_y, start_z, ctrl_x, ctrl_y, ctrl_z, end_x, end_y, end_z
	logic [143:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	// sample_index[4:0], out_x[20:5], out_y[36:21], out_z[52:37], zero pad
	logic [55:0]  m_axis_tdata;
	logic         m_axis_tlast;

	quadratic_bezier_point_generator_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// Requests waiting to be offered, and samples the block still owes us.
	logic [143:0] pending_curves[$];
	curve_point_t owed_samples[$];

	logic [5:0] point_count_shadow;   // our copy of the count register
	logic       req_fire;             // request transfer seen at the last rising edge
	int         fail_count;
	int         quiet_cycles;

	// Idle shaping knobs, set per phase by the stimulus block.
	bit sender_steady;
	bit sink_steady;
	bit hold_request;
	int burst_left;
	int gap_left;
	int hold_left;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		fail_count++;
		// keep the log bounded if the block is badly broken
		if (fail_count <= 60)
			$display("%0t: %s got %h expected %h", $realtime, what, got, want);
	endtask

	// floor((wa*p0 + wb*p1 + wc*p2) / 2^32); weights sum to 2^32 so the
	// result always fits back into Q7.8.
	function automatic logic [15:0] mix_axis(longint wa, longint wb, longint wc,
			logic signed [15:0] p0, logic signed [15:0] p1, logic signed [15:0] p2);
		longint acc;
		acc = wa * longint'(p0) + wb * longint'(p1) + wc * longint'(p2);
		return 16'(acc >>> 32);
	endfunction

	// Expand one accepted request into the samples it must produce.
	function automatic void predict_curve(logic [143:0] req);
		logic signed [15:0] pt[9];
		curve_point_t       s;
		int                 n;
		longint             t;
		longint             u;
		for (int k = 0; k < 9; k++)
			pt[k] = req[16*k +: 16];
		// zero acts as one, anything past the limit clamps
		n = (point_count_shadow == 0) ? 1 : int'(point_count_shadow);
		if (n > qbpg_pkg::POINT_LIMIT)
			n = qbpg_pkg::POINT_LIMIT;
		for (int i = 0; i < n; i++) begin
			s.index = 5'(i);
			if (i == n - 1) begin
				// final sample is the end point, bit for bit
				s.x = pt[6];
				s.y = pt[7];
				s.z = pt[8];
				s.last = 1'b1;
			end else begin
				t = (longint'(i) << 16) / longint'(n - 1);
				u = 65536 - t;
				s.x = mix_axis(u * u, 2 * u * t, t * t, pt[0], pt[3], pt[6]);
				s.y = mix_axis(u * u, 2 * u * t, t * t, pt[1], pt[4], pt[7]);
				s.z = mix_axis(u * u, 2 * u * t, t * t, pt[2], pt[5], pt[8]);
				s.last = 1'b0;
			end
			owed_samples.push_back(s);
		end
	endfunction

	// Request driver: bursts of random length, separated by random gaps unless sender_steady is set.
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || req_fire)) begin
			if (gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_curves.size() > 0) begin
				s_axis_tdata  <= pending_curves.pop_front();
				s_axis_tvalid <= 1'b1;
				if (burst_left > 0)
					burst_left--;
				else begin
					burst_left = $urandom_range(0, 9);
					gap_left = sender_steady ? 0 : $urandom_range(1, 10);
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Sample receiver: random stalls unless sink_steady is set, plus the long hold-off on request.
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left = LONG_HOLD;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= sink_steady || ($urandom_range(0, 3) != 0);
		end
	end

	// Monitor: tracks config and request transfers, checks every sample transfer.
	always @(posedge clk) begin
		curve_point_t want;
		req_fire <= s_axis_tvalid && s_axis_tready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				point_count_shadow <= cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				predict_curve(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				if (owed_samples.size() == 0) begin
					report_mismatch("unexpected sample, index", 16'(m_axis_tdata[4:0]), 16'h0);
				end else begin
					want = owed_samples.pop_front();
					if (m_axis_tdata[4:0] !== want.index)
						report_mismatch("sample_index", 16'(m_axis_tdata[4:0]), 16'(want.index));
					if (m_axis_tdata[20:5] !== want.x)
						report_mismatch("out_x", m_axis_tdata[20:5], want.x);
					if (m_axis_tdata[36:21] !== want.y)
						report_mismatch("out_y", m_axis_tdata[36:21], want.y);
					if (m_axis_tdata[52:37] !== want.z)
						report_mismatch("out_z", m_axis_tdata[52:37], want.z);
					if (m_axis_tlast !== want.last)
						report_mismatch("is_last", 16'(m_axis_tlast), 16'(want.last));
				end
			end
		end
	end

	// Watchdog: any transfer on any channel counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready)
				|| (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= STALL_LIMIT) begin
			$display("quadratic_bezier_point_generator_top_test NOT OK");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// Random coordinate, weighted toward the corners and the middle of the Q7.8 range.
	function automatic logic [15:0] pick_coord();
		case ($urandom_range(0, 5))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'($signed($urandom_range(0, 512)) - 256);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [143:0] random_curve();
		logic [143:0] c;
		for (int k = 0; k < 9; k++)
			c[16*k +: 16] = pick_coord();
		// now and then a degenerate curve: all three points equal
		if ($urandom_range(0, 9) == 0)
			c = {3{c[47:0]}};
		return c;
	endfunction

	function automatic logic [143:0] make_curve(logic [15:0] p0, logic [15:0] p1,
			logic [15:0] p2);
		return {{3{p2}}, {3{p1}}, {3{p0}}};
	endfunction

	task automatic queue_random(int count);
		for (int k = 0; k < count; k++)
			pending_curves.push_back(random_curve());
	endtask

	// Block until every queued request went in and every sample came out.
	task automatic drain();
		do begin
			@(posedge clk);
			#1;
		end while (pending_curves.size() != 0 || s_axis_tvalid || owed_samples.size() != 0);
		// let the pipeline settle before touching the register
		repeat (4) @(posedge clk);
	endtask

	task automatic write_point_count(logic [5:0] value);
		@(negedge clk);
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic shuffle_idling();
		sender_steady = ($urandom_range(0, 3) == 0);
		sink_steady   = ($urandom_range(0, 3) == 0);
	endtask

	initial begin
		logic [5:0] cnt;
		arst_n             = 1'b0;
		cfg_valid          = 1'b0;
		cfg_data           = '0;
		s_axis_tvalid      = 1'b0;
		s_axis_tdata       = '0;
		m_axis_tready      = 1'b0;
		point_count_shadow = 6'(qbpg_pkg::CNT_RESET);
		req_fire           = 1'b0;
		fail_count         = 0;
		quiet_cycles       = 0;
		sender_steady      = 1'b1;
		sink_steady        = 1'b1;
		hold_request       = 1'b0;
		burst_left         = 0;
		gap_left           = 0;
		hold_left          = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed curves at the reset count of 16, no idling first.
		pending_curves.push_back(make_curve(16'h0000, 16'h0000, 16'h0000));
		pending_curves.push_back(make_curve(16'h7FFF, 16'h7FFF, 16'h7FFF));
		pending_curves.push_back(make_curve(16'h8000, 16'h8000, 16'h8000));
		pending_curves.push_back(make_curve(16'h8000, 16'h0000, 16'h7FFF));
		pending_curves.push_back(make_curve(16'h7FFF, 16'h0000, 16'h8000));
		pending_curves.push_back(make_curve(16'h0000, 16'h7FFF, 16'h0000));
		pending_curves.push_back(make_curve(16'h0000, 16'h8000, 16'h0000));
		pending_curves.push_back(make_curve(16'h8000, 16'h7FFF, 16'h8000));
		pending_curves.push_back(make_curve(16'h7FFF, 16'h8000, 16'h7FFF));
		// tiny negatives: truncation goes toward minus infinity
		pending_curves.push_back(make_curve(16'hFFFF, 16'h0000, 16'h0001));
		pending_curves.push_back(make_curve(16'h0001, 16'hFFFF, 16'hFFFF));
		// alternating bit patterns so every tdata bit toggles
		pending_curves.push_back(make_curve(16'h5555, 16'hAAAA, 16'h5555));
		pending_curves.push_back(make_curve(16'hAAAA, 16'h5555, 16'hAAAA));
		pending_curves.push_back({16'h8000, 16'h7FFF, 16'h0100, 16'hFF00, 16'h1234,
				16'hEDCB, 16'h0001, 16'hFFFF, 16'h4000});
		drain();

		// Count extremes and the clamped/degenerate settings.
		write_point_count(6'd1);
		pending_curves.push_back(make_curve(16'h8000, 16'h7FFF, 16'h1234));
		queue_random(4);
		drain();

		write_point_count(6'd0);   // zero behaves like one
		shuffle_idling();
		queue_random(5);
		drain();

		write_point_count(6'd2);
		shuffle_idling();
		pending_curves.push_back(make_curve(16'h8000, 16'h7FFF, 16'h7FFF));
		queue_random(6);
		drain();

		// Full-length curves while the receiver holds off for a long stretch:
		// the sender keeps offering so the block backs up and stalls its input.
		write_point_count(6'd32);
		sender_steady = 1'b1;
		sink_steady   = 1'b0;
		hold_request  = 1'b1;
		pending_curves.push_back(make_curve(16'h8000, 16'h7FFF, 16'h8000));
		queue_random(9);
		drain();

		write_point_count(6'd63);  // clamps to the limit
		shuffle_idling();
		queue_random(6);
		drain();

		write_point_count(6'd33);
		shuffle_idling();
		queue_random(4);
		drain();

		// Random phases: random counts, mostly short curves to keep the run brisk.
		for (int ph = 0; ph < 8; ph++) begin
			cnt = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
					: 6'($urandom_range(1, 8));
			write_point_count(cnt);
			shuffle_idling();
			queue_random(12);
			drain();
		end

		// Back to the reset value, with one more pressure burst.
		write_point_count(6'd16);
		sender_steady = 1'b1;
		sink_steady   = 1'b0;
		hold_request  = 1'b1;
		queue_random(6);
		drain();

		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("quadratic_bezier_point_generator_top_test OK");
		else
			$display("quadratic_bezier_point_generator_top_test NOT OK");
		$finish;
	end

endmodule
